### src/twa_pkg.sv
// Shared constants and types of the thermal window average and fan duty block.
package twa_pkg;

   localparam int CHANNELS   = 6;
   localparam int TEMP_W     = 8;
   localparam int AVG_W      = 8;
   localparam int DUTY_W     = 10;
   localparam int SUM_W      = 11;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam int DIV_NUM_W  = 18;
   localparam int DIV_DEN_W  = 8;

   // Floor of sum / CHANNELS as (sum * MEAN_RECIP) >> MEAN_SHIFT, exact for sums below 2048.
   localparam int               MEAN_SHIFT = 14;
   localparam logic [11:0]      MEAN_RECIP = 12'd2731;

   localparam logic [DUTY_W-1:0] DUTY_FULL = 10'd1000;

   localparam logic [CSR_IDX_W-1:0]  CSR_FAN_MIN   = 4'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_FAN_MAX   = 4'd1;
   localparam logic [CSR_DATA_W-1:0] FAN_MIN_RESET = 8'd50;
   localparam logic [CSR_DATA_W-1:0] FAN_MAX_RESET = 8'd100;

   typedef logic [TEMP_W-1:0] temp_type;
   typedef logic [AVG_W-1:0]  avg_type;

endpackage

### src/twa_div.sv
// Restoring divider producing one quotient bit per cycle.
module twa_div
   import twa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W-1:0] rem_ff;

   logic [DIV_DEN_W:0]   rem_shift;
   logic                 fits;
   logic [DIV_DEN_W-1:0] rem_in;

   always_comb begin
      rem_shift = {rem_ff, num_ff[DIV_NUM_W-1]};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_in    = fits ? DIV_DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DIV_DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // pulse done for one cycle after the last quotient bit
         done_ff <= busy_ff && !start && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_NUM_W);
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            // shift one numerator bit into the remainder, one quotient bit out
            rem_ff <= rem_in;
            num_ff <= {num_ff[DIV_NUM_W-2:0], fits};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = num_ff;

endmodule

### src/thermal_window_average_fan_duty.sv
// Top level: six-channel moving window temperature average with a linear fan duty curve.
//
// Each request carries one temperature per channel. The block steps a ring pointer over a
// WINDOW-deep sample store, then walks the six channels one per cycle: it removes the
// stored share floor(old/WINDOW) of the slot it overwrites from that channel's running
// average and adds floor(new/WINDOW). The store keeps those shares, one 48-bit row per
// slot; rows not yet written since reset read as zero through a per-row valid bit, so no
// clearing pass is needed. The floor mean of the six averages is mapped to a fan duty of
// 0 below fan_min_temp, 1000 above fan_max_temp (or whenever fan_max_temp <= fan_min_temp
// and the mean is not below fan_min_temp), and floor(1000*(mean-min)/(max-min)) in
// between. After the channel walk, the duty is set directly when the mean lies outside the
// proportional band and by the 18-step bit-serial duty divider inside it. A new request is
// taken as soon as the previous one is in the response register, even if that response still
// waits for rsp_ready. Register writes on the csr port are always taken at once.
module thermal_window_average_fan_duty
   import twa_pkg::*;
#(
   parameter int WINDOW = 16
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TEMP_W-1:0]     req_temp_ch0,
   input  logic [TEMP_W-1:0]     req_temp_ch1,
   input  logic [TEMP_W-1:0]     req_temp_ch2,
   input  logic [TEMP_W-1:0]     req_temp_ch3,
   input  logic [TEMP_W-1:0]     req_temp_ch4,
   input  logic [TEMP_W-1:0]     req_temp_ch5,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [AVG_W-1:0]      rsp_avg_ch0,
   output logic [AVG_W-1:0]      rsp_avg_ch1,
   output logic [AVG_W-1:0]      rsp_avg_ch2,
   output logic [AVG_W-1:0]      rsp_avg_ch3,
   output logic [AVG_W-1:0]      rsp_avg_ch4,
   output logic [AVG_W-1:0]      rsp_avg_ch5,
   output logic [DUTY_W-1:0]     rsp_fan_duty
);

   localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int ROW_W = CHANNELS * AVG_W;
   localparam int CH_W  = $clog2(CHANNELS);

   // floor(s/WINDOW) for an 8-bit s as (s * WIN_RECIP) >> 16
   localparam int               WIN_SHIFT = 16;
   localparam logic [16:0]      WIN_RECIP = 17'((2 ** WIN_SHIFT + WINDOW - 1) / WINDOW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHAN,
      ST_MEAN,
      ST_CURVE,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [CSR_DATA_W-1:0] fan_min_ff;
   logic [CSR_DATA_W-1:0] fan_max_ff;

   // window store of per-slot shares
   logic [ROW_W-1:0]  share_mem [WINDOW];
   logic [ROW_W-1:0]  rd_row_ff;
   logic              rd_ok_ff;
   logic [WINDOW-1:0] row_ok_ff;
   logic [PTR_W-1:0]  ptr_ff;
   logic [PTR_W-1:0]  ptr_in;

   // channel walk
   logic [ROW_W-1:0]    smp_ff;
   logic [ROW_W-1:0]    new_row_ff;
   avg_type             avg_ff [CHANNELS];
   logic [CH_W-1:0]     ch_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [AVG_W-1:0]    mean_ff;
   logic [DUTY_W-1:0]   duty_ff;

   // response register
   logic                rsp_valid_ff;
   avg_type             rsp_avg_ff [CHANNELS];
   logic [DUTY_W-1:0]   rsp_duty_ff;

   logic                req_accept;
   logic                last_ch;
   logic [AVG_W-1:0]    old_share;
   logic [24:0]         new_prod;
   logic [AVG_W-1:0]    new_share;
   logic [AVG_W:0]      avg_upd;
   logic [ROW_W-1:0]    row_in;
   logic                row_wr;
   logic [SUM_W+11:0]   mean_prod;
   logic [AVG_W-1:0]    mean_in;
   logic [AVG_W-1:0]    band_off;
   logic [DIV_DEN_W-1:0] band_span;
   logic                in_band;
   logic                div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic                div_done;
   logic [DIV_NUM_W-1:0] div_quo;
   logic                out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_accept = req_valid && req_ready;

   assign ptr_in = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + PTR_W'(1);

   always_comb begin
      last_ch   = (ch_ff == CH_W'(CHANNELS - 1));
      old_share = rd_ok_ff ? rd_row_ff[ch_ff*AVG_W +: AVG_W] : '0;
      new_prod  = smp_ff[TEMP_W-1:0] * WIN_RECIP;
      new_share = new_prod[WIN_SHIFT+AVG_W-1:WIN_SHIFT];
      avg_upd   = {1'b0, avg_ff[0]} - {1'b0, old_share} + {1'b0, new_share};
      row_in    = {new_share, new_row_ff[ROW_W-1:AVG_W]};
      row_wr    = (state_ff == ST_CHAN) && last_ch;

      mean_prod = sum_ff * MEAN_RECIP;
      mean_in   = mean_prod[MEAN_SHIFT+AVG_W-1:MEAN_SHIFT];

      band_off  = mean_ff - fan_min_ff;
      band_span = fan_max_ff - fan_min_ff;
      in_band   = (mean_ff >= fan_min_ff) && (mean_ff <= fan_max_ff) && (fan_max_ff > fan_min_ff);
      div_start = (state_ff == ST_CURVE) && in_band;
      div_num   = DIV_NUM_W'(DUTY_FULL) * DIV_NUM_W'(band_off);

      out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Store the new row of shares at the end of the walk; read the slot being replaced on
   // acceptance so its shares are ready for the first channel.
   always_ff @(posedge clock) begin
      if (row_wr) begin
         share_mem[ptr_ff] <= row_in;
      end
      if (req_accept) begin
         rd_row_ff <= share_mem[ptr_in];
      end
   end

   twa_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (band_span),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         row_ok_ff    <= '0;
         ch_ff        <= '0;
         fan_min_ff   <= FAN_MIN_RESET;
         fan_max_ff   <= FAN_MAX_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            avg_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FAN_MIN) begin
               fan_min_ff <= csr_data;
            end else if (csr_index == CSR_FAN_MAX) begin
               fan_max_ff <= csr_data;
            end
         end

         // drop the response once taken, unless a new one is loaded below
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  ptr_ff   <= ptr_in;
                  rd_ok_ff <= row_ok_ff[ptr_in];
                  smp_ff   <= {req_temp_ch5, req_temp_ch4, req_temp_ch3,
                               req_temp_ch2, req_temp_ch1, req_temp_ch0};
                  ch_ff    <= '0;
                  sum_ff   <= '0;
                  state_ff <= ST_CHAN;
               end
            end
            ST_CHAN: begin
               // update the head channel, rotate the averages, advance the samples
               for (int i = 0; i < CHANNELS - 1; i++) begin
                  avg_ff[i] <= avg_ff[i+1];
               end
               avg_ff[CHANNELS-1] <= avg_upd[AVG_W-1:0];
               sum_ff     <= sum_ff + SUM_W'(avg_upd[AVG_W-1:0]);
               smp_ff     <= {{TEMP_W{1'b0}}, smp_ff[ROW_W-1:TEMP_W]};
               new_row_ff <= row_in;
               ch_ff      <= ch_ff + CH_W'(1);
               if (last_ch) begin
                  row_ok_ff[ptr_ff] <= 1'b1;
                  state_ff          <= ST_MEAN;
               end
            end
            ST_MEAN: begin
               mean_ff  <= mean_in;
               state_ff <= ST_CURVE;
            end
            ST_CURVE: begin
               if (mean_ff < fan_min_ff) begin
                  duty_ff  <= '0;
                  state_ff <= ST_OUT;
               end else if (!in_band) begin
                  duty_ff  <= DUTY_FULL;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  duty_ff  <= div_quo[DUTY_W-1:0];
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               // hold until the response register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_duty_ff  <= duty_ff;
                  for (int i = 0; i < CHANNELS; i++) begin
                     rsp_avg_ff[i] <= avg_ff[i];
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_avg_ch0  = rsp_avg_ff[0];
   assign rsp_avg_ch1  = rsp_avg_ff[1];
   assign rsp_avg_ch2  = rsp_avg_ff[2];
   assign rsp_avg_ch3  = rsp_avg_ff[3];
   assign rsp_avg_ch4  = rsp_avg_ff[4];
   assign rsp_avg_ch5  = rsp_avg_ff[5];
   assign rsp_fan_duty = rsp_duty_ff;

`ifndef SYNTHESIS
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fan_duty <= DUTY_FULL)
      else $error("fan duty above full scale");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_accept_walk: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_CHAN && ch_ff == '0)
      else $error("accepted request did not start the channel walk");

   a_walk_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHAN |-> ch_ff <= CH_W'(CHANNELS - 1))
      else $error("channel counter out of range");

   a_row_written: assert property (@(posedge clock) disable iff (reset)
      row_wr |=> row_ok_ff[ptr_ff] && state_ff == ST_MEAN)
      else $error("window row not marked valid after its write");
`endif

endmodule
